FILE: hdl/cc20x_pkg.sv
// ----------------------------------------------------------------------------
// cc20x_pkg
// Shared types and constants for the ChaCha20 byte-stream XOR block.
// ----------------------------------------------------------------------------
package cc20x_pkg;

    // "expand 32-byte k"
    localparam logic [31:0] CC_CONST0 = 32'h6170_7865;
    localparam logic [31:0] CC_CONST1 = 32'h3320_646e;
    localparam logic [31:0] CC_CONST2 = 32'h7962_2d32;
    localparam logic [31:0] CC_CONST3 = 32'h6b20_6574;

    localparam int DOUBLE_ROUNDS = 10;
    localparam int ROUND_COUNT   = 2 * DOUBLE_ROUNDS;
    localparam int ROUND_W       = $clog2(ROUND_COUNT);
    localparam int STATE_WORDS   = 16;
    localparam int WORD_IDX_W    = $clog2(STATE_WORDS);
    localparam int BLOCK_BYTES   = 64;
    localparam int POS_W         = $clog2(BLOCK_BYTES);

    // Configuration register indexes (paddr[5:3]).
    localparam logic [2:0] REG_KEY_01    = 3'd0;
    localparam logic [2:0] REG_KEY_23    = 3'd1;
    localparam logic [2:0] REG_KEY_45    = 3'd2;
    localparam logic [2:0] REG_KEY_67    = 3'd3;
    localparam logic [2:0] REG_NONCE     = 3'd4;
    localparam logic [2:0] REG_START_CNT = 3'd5;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_ROUND,
        ST_STORE,
        ST_READ,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic load;   // load working state from the init words
        logic shift;  // shift working words down by one
    } core_ctrl_t;

    typedef struct packed {
        logic busy;   // rounds in progress
        logic done;   // one-cycle pulse after the last round
    } core_stat_t;

endpackage

FILE: hdl/cc20x_core.sv
// ----------------------------------------------------------------------------
// cc20x_core
// ChaCha20 round engine: four quarter-round lanes, one add/xor/rotate step
// per lane per cycle, working words held in registers.
// ----------------------------------------------------------------------------
module cc20x_core
    import cc20x_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  core_ctrl_t        ctrl,
    input  logic [31:0]       init_words [STATE_WORDS],
    output core_stat_t        stat,
    output logic [31:0]       head_word
);

    logic [31:0]        w_reg  [STATE_WORDS];
    logic [31:0]        w_next [STATE_WORDS];
    logic [1:0]         step_reg;
    logic [1:0]         step_next;
    logic [ROUND_W-1:0] round_reg;
    logic [ROUND_W-1:0] round_next;
    logic               active_reg;
    logic               active_next;
    logic               done_reg;
    logic               done_next;

    logic [31:0] lane_a  [4];
    logic [31:0] lane_b  [4];
    logic [31:0] lane_c  [4];
    logic [31:0] lane_d  [4];
    logic [31:0] new_a   [4];
    logic [31:0] new_b   [4];
    logic [31:0] new_c   [4];
    logic [31:0] new_d   [4];

    function automatic logic [31:0] rot_step(input logic [31:0] v, input logic [1:0] s);
        logic [31:0] r;
        case (s)
            2'd0:    r = {v[15:0], v[31:16]};
            2'd1:    r = {v[19:0], v[31:20]};
            2'd2:    r = {v[23:0], v[31:24]};
            2'd3:    r = {v[24:0], v[31:25]};
            default: r = v;
        endcase
        return r;
    endfunction

    // Lane operands: column round on even rounds, diagonal round on odd.
    always_comb
    begin
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic [31:0] xs;
        logic [31:0] zs;
        for (int q = 0; q < 4; q++)
        begin
            lane_a[q] = w_reg[q];
            if (round_reg[0])
            begin
                lane_b[q] = w_reg[4 + ((q + 1) & 3)];
                lane_c[q] = w_reg[8 + ((q + 2) & 3)];
                lane_d[q] = w_reg[12 + ((q + 3) & 3)];
            end
            else
            begin
                lane_b[q] = w_reg[4 + q];
                lane_c[q] = w_reg[8 + q];
                lane_d[q] = w_reg[12 + q];
            end
            if (!step_reg[0])
            begin
                x = lane_a[q];
                y = lane_b[q];
                z = lane_d[q];
            end
            else
            begin
                x = lane_c[q];
                y = lane_d[q];
                z = lane_b[q];
            end
            xs = x + y;
            zs = rot_step(z ^ xs, step_reg);
            if (!step_reg[0])
            begin
                new_a[q] = xs;
                new_d[q] = zs;
                new_b[q] = lane_b[q];
                new_c[q] = lane_c[q];
            end
            else
            begin
                new_c[q] = xs;
                new_b[q] = zs;
                new_a[q] = lane_a[q];
                new_d[q] = lane_d[q];
            end
        end
    end

    always_comb
    begin
        w_next      = w_reg;
        step_next   = step_reg;
        round_next  = round_reg;
        active_next = active_reg;
        done_next   = 1'b0;
        if (ctrl.load)
        begin
            w_next      = init_words;
            step_next   = '0;
            round_next  = '0;
            active_next = 1'b1;
        end
        else if (active_reg)
        begin
            for (int q = 0; q < 4; q++)
            begin
                w_next[q] = new_a[q];
                if (round_reg[0])
                begin
                    w_next[4 + ((q + 1) & 3)]  = new_b[q];
                    w_next[8 + ((q + 2) & 3)]  = new_c[q];
                    w_next[12 + ((q + 3) & 3)] = new_d[q];
                end
                else
                begin
                    w_next[4 + q]  = new_b[q];
                    w_next[8 + q]  = new_c[q];
                    w_next[12 + q] = new_d[q];
                end
            end
            step_next = step_reg + 2'd1;
            if (step_reg == 2'd3)
            begin
                if (round_reg == ROUND_W'(ROUND_COUNT - 1))
                begin
                    active_next = 1'b0;
                    done_next   = 1'b1;
                end
                else
                begin
                    round_next = round_reg + ROUND_W'(1);
                end
            end
        end
        else if (ctrl.shift)
        begin
            for (int i = 0; i < STATE_WORDS - 1; i++)
            begin
                w_next[i] = w_reg[i + 1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg   <= '0;
            round_reg  <= '0;
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            step_reg   <= step_next;
            round_reg  <= round_next;
            active_reg <= active_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        w_reg <= w_next;
    end

    assign stat.busy = active_reg;
    assign stat.done = done_reg;
    assign head_word = w_reg[0];

endmodule

FILE: hdl/chacha20_stream_xor.sv
// ----------------------------------------------------------------------------
// A byte inside a block passes the read state and the output state; its result
// is registered once the output is not stalled, and no new byte is taken until
// then. A byte at block position 0 first runs a block: a load, the round steps,
// the done pulse from the engine, then the 16 keystream words written to memory.
// Reset clears the FSM, counters, output valid and configuration registers; memory is not.
// ----------------------------------------------------------------------------
// chacha20_stream_xor
// XORs a byte stream with ChaCha20 keystream held in a 16-word memory.
// ----------------------------------------------------------------------------
module chacha20_stream_xor
    import cc20x_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    input  logic        data_valid,
    output logic        data_stall,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [7:0]  result_byte,
    output logic        result_last
);

    logic [63:0] key01_reg;
    logic [63:0] key23_reg;
    logic [63:0] key45_reg;
    logic [63:0] key67_reg;
    logic [63:0] nonce_reg;
    logic [31:0] start_cnt_reg;

    state_t               state_reg;
    state_t               state_next;
    logic [31:0]          block_count_reg;
    logic [POS_W-1:0]     pos_reg;
    logic                 open_reg;
    logic [POS_W-1:0]     item_pos_reg;
    logic [7:0]           item_byte_reg;
    logic                 item_last_reg;
    logic [WORD_IDX_W-1:0] st_idx_reg;
    logic [31:0]          rd_data_reg;
    logic                 out_valid_reg;
    logic [7:0]           out_byte_reg;
    logic                 out_last_reg;

    logic [31:0]          ks_mem [STATE_WORDS];
    logic [31:0]          init_words [STATE_WORDS];
    logic [31:0]          head_word;
    logic [POS_W-1:0]     pos_eff;
    logic                 accept;
    logic                 cfg_write;
    logic                 mem_we;
    logic                 out_load;
    logic [7:0]           ks_byte;
    core_ctrl_t           core_ctrl;
    core_stat_t           core_stat;

    // ---------------- configuration port ----------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key01_reg     <= '0;
            key23_reg     <= '0;
            key45_reg     <= '0;
            key67_reg     <= '0;
            nonce_reg     <= '0;
            start_cnt_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (paddr[5:3])
                REG_KEY_01:    key01_reg     <= pwdata;
                REG_KEY_23:    key23_reg     <= pwdata;
                REG_KEY_45:    key45_reg     <= pwdata;
                REG_KEY_67:    key67_reg     <= pwdata;
                REG_NONCE:     nonce_reg     <= pwdata;
                REG_START_CNT: start_cnt_reg <= pwdata[31:0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[5:3])
            REG_KEY_01:    prdata = key01_reg;
            REG_KEY_23:    prdata = key23_reg;
            REG_KEY_45:    prdata = key45_reg;
            REG_KEY_67:    prdata = key67_reg;
            REG_NONCE:     prdata = nonce_reg;
            REG_START_CNT: prdata = {32'd0, start_cnt_reg};
            default:       prdata = '0;
        endcase
    end

    // ---------------- block input words ----------------
    always_comb
    begin
        init_words[0]  = CC_CONST0;
        init_words[1]  = CC_CONST1;
        init_words[2]  = CC_CONST2;
        init_words[3]  = CC_CONST3;
        init_words[4]  = key01_reg[31:0];
        init_words[5]  = key01_reg[63:32];
        init_words[6]  = key23_reg[31:0];
        init_words[7]  = key23_reg[63:32];
        init_words[8]  = key45_reg[31:0];
        init_words[9]  = key45_reg[63:32];
        init_words[10] = key67_reg[31:0];
        init_words[11] = key67_reg[63:32];
        init_words[12] = block_count_reg;
        init_words[13] = nonce_reg[31:0];
        init_words[14] = nonce_reg[63:32];
        init_words[15] = 32'd0;
    end

    cc20x_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (core_ctrl),
        .init_words (init_words),
        .stat       (core_stat),
        .head_word  (head_word)
    );

    // ---------------- control ----------------
    assign data_stall = (state_reg != ST_IDLE);
    assign accept     = data_valid && !data_stall;
    assign pos_eff    = open_reg ? pos_reg : '0;
    assign out_load   = (state_reg == ST_OUT) && (!out_valid_reg || !result_stall);

    always_comb
    begin
        state_next      = state_reg;
        core_ctrl.load  = 1'b0;
        core_ctrl.shift = 1'b0;
        mem_we          = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = (pos_eff == '0) ? ST_LOAD : ST_READ;
                end
            end
            ST_LOAD:
            begin
                core_ctrl.load = 1'b1;
                state_next     = ST_ROUND;
            end
            ST_ROUND:
            begin
                if (core_stat.done)
                begin
                    state_next = ST_STORE;
                end
            end
            ST_STORE:
            begin
                core_ctrl.shift = 1'b1;
                mem_we          = 1'b1;
                if (st_idx_reg == WORD_IDX_W'(STATE_WORDS - 1))
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            block_count_reg <= '0;
            pos_reg         <= '0;
            open_reg        <= 1'b0;
            item_pos_reg    <= '0;
            st_idx_reg      <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                if (!open_reg)
                begin
                    block_count_reg <= start_cnt_reg;
                end
                item_pos_reg <= pos_eff;
                pos_reg      <= pos_eff + POS_W'(1);
                open_reg     <= !last_byte;
                st_idx_reg   <= '0;
            end
            if (mem_we)
            begin
                st_idx_reg <= st_idx_reg + WORD_IDX_W'(1);
                if (st_idx_reg == WORD_IDX_W'(STATE_WORDS - 1))
                begin
                    block_count_reg <= block_count_reg + 32'd1;
                end
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_byte_reg <= data_byte;
            item_last_reg <= last_byte;
        end
        if (out_load)
        begin
            out_byte_reg <= item_byte_reg ^ ks_byte;
            out_last_reg <= item_last_reg;
        end
    end

    // ---------------- keystream memory ----------------
    // The feed-forward add happens as the words stream out of the core.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            ks_mem[st_idx_reg] <= head_word + init_words[st_idx_reg];
        end
        rd_data_reg <= ks_mem[item_pos_reg[POS_W-1:2]];
    end

    always_comb
    begin
        case (item_pos_reg[1:0])
            2'd0:    ks_byte = rd_data_reg[7:0];
            2'd1:    ks_byte = rd_data_reg[15:8];
            2'd2:    ks_byte = rd_data_reg[23:16];
            2'd3:    ks_byte = rd_data_reg[31:24];
            default: ks_byte = rd_data_reg[7:0];
        endcase
    end

    assign result_valid = out_valid_reg;
    assign result_byte  = out_byte_reg;
    assign result_last  = out_last_reg;

    // ---------------- assertions ----------------
    a_gen_at_block_start: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (pos_eff == '0) |=> state_reg == ST_LOAD)
        else $error("block start did not launch keystream generation");

    a_count_after_store: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we && (st_idx_reg == WORD_IDX_W'(STATE_WORDS - 1))
        |=> block_count_reg == $past(block_count_reg) + 32'd1)
        else $error("block counter did not advance after a block");

    a_rounds_running: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_ROUND |-> core_stat.busy || core_stat.done)
        else $error("round engine idle while waiting for a block");

    a_result_from_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(state_reg) == ST_OUT)
        else $error("result beat raised outside the output state");

endmodule

FILE: test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks the ChaCha20 byte-stream XOR block against a cycle-free predictor.
// Message bytes go in one beat at a time. Each result beat is compared with
// the keystream byte that the predictor generates from the registers, the
// message counter and the byte position. Keys, nonce and start counter are
// rewritten between phases, sometimes while a message is still open.
// ----------------------------------------------------------------------------
module testbench;
    import cc20x_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 4;
    localparam int TAIL_CYCLES    = 150;
    localparam int RANDOM_PHASES  = 12;

    // Decoded by the block but backed by no register; writes must be dropped.
    localparam logic [2:0] REG_SPARE_A = 3'd6;
    localparam logic [2:0] REG_SPARE_B = 3'd7;

    typedef struct packed {
        logic [7:0] byte_val;
        logic       is_last;
    } byte_beat_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [5:0]  paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic        pready;
    logic        data_valid = 1'b0;
    logic        data_stall;
    logic [7:0]  data_byte = '0;
    logic        last_byte = 1'b0;
    logic        result_valid;
    logic        result_stall = 1'b0;
    logic [7:0]  result_byte;
    logic        result_last;

    // Predictor state: register copies and the keystream position.
    logic [63:0] key01_reg = '0;
    logic [63:0] key23_reg = '0;
    logic [63:0] key45_reg = '0;
    logic [63:0] key67_reg = '0;
    logic [63:0] nonce_reg = '0;
    logic [31:0] start_ctr_reg = '0;
    logic [31:0] ks_words [STATE_WORDS];
    logic [31:0] blk_count = '0;
    logic [5:0]  byte_pos = '0;
    logic        msg_open = 1'b0;

    byte_beat_t  plain_q [$];
    byte_beat_t  cipher_q [$];

    bit          quiet = 1'b0;
    int          send_gap = 0;
    int          stall_left = 0;
    int          idle_cycles = 0;
    int          mismatches = 0;
    int          msg_left = 0;

    chacha20_stream_xor i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .data_valid   (data_valid),
        .data_stall   (data_stall),
        .data_byte    (data_byte),
        .last_byte    (last_byte),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_byte  (result_byte),
        .result_last  (result_last)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic logic [31:0] rotl32(logic [31:0] x, int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    function automatic logic [127:0] quarter_round(logic [31:0] a, logic [31:0] b,
                                                   logic [31:0] c, logic [31:0] d);
        a = a + b; d = rotl32(d ^ a, 16);
        c = c + d; b = rotl32(b ^ c, 12);
        a = a + b; d = rotl32(d ^ a, 8);
        c = c + d; b = rotl32(b ^ c, 7);
        return {a, b, c, d};
    endfunction

    function automatic void refill_keystream();
        logic [31:0] init_w [STATE_WORDS];
        logic [31:0] w [STATE_WORDS];
        init_w[0]  = CC_CONST0;
        init_w[1]  = CC_CONST1;
        init_w[2]  = CC_CONST2;
        init_w[3]  = CC_CONST3;
        init_w[4]  = key01_reg[31:0];
        init_w[5]  = key01_reg[63:32];
        init_w[6]  = key23_reg[31:0];
        init_w[7]  = key23_reg[63:32];
        init_w[8]  = key45_reg[31:0];
        init_w[9]  = key45_reg[63:32];
        init_w[10] = key67_reg[31:0];
        init_w[11] = key67_reg[63:32];
        init_w[12] = blk_count;
        init_w[13] = nonce_reg[31:0];
        init_w[14] = nonce_reg[63:32];
        init_w[15] = '0;
        w = init_w;
        for (int i = 0; i < DOUBLE_ROUNDS; i++)
        begin
            {w[0], w[4], w[8],  w[12]} = quarter_round(w[0], w[4], w[8],  w[12]);
            {w[1], w[5], w[9],  w[13]} = quarter_round(w[1], w[5], w[9],  w[13]);
            {w[2], w[6], w[10], w[14]} = quarter_round(w[2], w[6], w[10], w[14]);
            {w[3], w[7], w[11], w[15]} = quarter_round(w[3], w[7], w[11], w[15]);
            {w[0], w[5], w[10], w[15]} = quarter_round(w[0], w[5], w[10], w[15]);
            {w[1], w[6], w[11], w[12]} = quarter_round(w[1], w[6], w[11], w[12]);
            {w[2], w[7], w[8],  w[13]} = quarter_round(w[2], w[7], w[8],  w[13]);
            {w[3], w[4], w[9],  w[14]} = quarter_round(w[3], w[4], w[9],  w[14]);
        end
        for (int i = 0; i < STATE_WORDS; i++)
            ks_words[i] = w[i] + init_w[i];
    endfunction

    function automatic void expect_cipher_byte(logic [7:0] plain, logic is_last);
        logic [7:0] ks;
        byte_beat_t beat;
        if (!msg_open)
        begin
            blk_count = start_ctr_reg;
            byte_pos  = '0;
            msg_open  = 1'b1;
        end
        // A fresh block is cut from the registers as they stand right now.
        if (byte_pos == '0)
        begin
            refill_keystream();
            blk_count = blk_count + 32'd1;
        end
        ks = ks_words[byte_pos[5:2]][{byte_pos[1:0], 3'b000} +: 8];
        byte_pos = byte_pos + 6'd1;
        if (is_last)
            msg_open = 1'b0;
        beat.byte_val = plain ^ ks;
        beat.is_last  = is_last;
        cipher_q.push_back(beat);
    endfunction

    function automatic void apply_register(logic [2:0] idx, logic [63:0] val);
        case (idx)
            REG_KEY_01:    key01_reg = val;
            REG_KEY_23:    key23_reg = val;
            REG_KEY_45:    key45_reg = val;
            REG_KEY_67:    key67_reg = val;
            REG_NONCE:     nonce_reg = val;
            REG_START_CNT: start_ctr_reg = val[31:0];
            default:       ;
        endcase
    endfunction

    function automatic void check_result(logic [7:0] got_byte, logic got_last);
        byte_beat_t want;
        if (cipher_q.size() == 0)
        begin
            if (mismatches < 10)
                $display("unexpected result beat: result_byte %02h result_last %0b",
                         got_byte, got_last);
            mismatches++;
        end
        else
        begin
            want = cipher_q.pop_front();
            if (got_byte !== want.byte_val)
            begin
                if (mismatches < 10)
                    $display("result_byte mismatch: expected %02h, got %02h",
                             want.byte_val, got_byte);
                mismatches++;
            end
            if (got_last !== want.is_last)
            begin
                if (mismatches < 10)
                    $display("result_last mismatch: expected %0b, got %0b",
                             want.is_last, got_last);
                mismatches++;
            end
        end
    endfunction

    // Sender: one beat per accepted handshake, with random gaps between beats.
    always @(posedge clk)
    begin
        byte_beat_t beat;
        if (!rst_n)
            data_valid <= 1'b0;
        else
        begin
            if (data_valid && !data_stall)
                expect_cipher_byte(data_byte, last_byte);
            if (!data_valid || !data_stall)
            begin
                if (send_gap != 0)
                begin
                    send_gap   <= send_gap - 1;
                    data_valid <= 1'b0;
                end
                else if (plain_q.size() != 0)
                begin
                    beat = plain_q.pop_front();
                    data_valid <= 1'b1;
                    data_byte  <= beat.byte_val;
                    last_byte  <= beat.is_last;
                    if (!quiet && $urandom_range(0, 7) == 0)
                        send_gap <= $urandom_range(1, 10);
                end
                else
                    data_valid <= 1'b0;
            end
        end
    end

    // Receiver: checks every accepted result and stalls in random bursts.
    always @(posedge clk)
    begin
        if (!rst_n)
            result_stall <= 1'b0;
        else
        begin
            if (result_valid && !result_stall)
                check_result(result_byte, result_last);
            if (stall_left != 0)
            begin
                stall_left   <= stall_left - 1;
                result_stall <= 1'b1;
            end
            else if (!quiet && $urandom_range(0, 11) == 0)
            begin
                stall_left   <= $urandom_range(0, 9);
                result_stall <= 1'b1;
            end
            else
                result_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (data_valid && !data_stall) || (result_valid && !result_stall) ||
            (psel && penable))
            idle_cycles <= 0;
        else if (idle_cycles == WATCHDOG_LIMIT)
        begin
            $display("testbench failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    task automatic reg_write(logic [2:0] idx, logic [63:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        apply_register(idx, val);
    endtask

    task automatic write_all(logic [63:0] k01, logic [63:0] k23, logic [63:0] k45,
                             logic [63:0] k67, logic [63:0] nonce, logic [31:0] ctr);
        reg_write(REG_KEY_01, k01);
        reg_write(REG_KEY_23, k23);
        reg_write(REG_KEY_45, k45);
        reg_write(REG_KEY_67, k67);
        reg_write(REG_NONCE, nonce);
        reg_write(REG_START_CNT, {32'd0, ctr});
    endtask

    task automatic wait_drained();
        while (plain_q.size() != 0 || data_valid || cipher_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic void queue_byte(logic [7:0] val, logic is_last);
        byte_beat_t beat;
        beat.byte_val = val;
        beat.is_last  = is_last;
        plain_q.push_back(beat);
    endfunction

    function automatic logic [63:0] pick_word64();
        int r;
        r = $urandom_range(0, 5);
        if (r == 0)
            return '0;
        else if (r == 1)
            return '1;
        else
            return {$urandom, $urandom};
    endfunction

    function automatic logic [31:0] pick_counter();
        int r;
        r = $urandom_range(0, 4);
        if (r == 0)
            return '0;
        else if (r == 1)
            return '1;
        else if (r == 2)
            return 32'hFFFF_FFFF - $urandom_range(0, 3);
        else
            return $urandom;
    endfunction

    // Messages run on across phase ends, so register writes also land mid-message.
    function automatic void queue_random_byte();
        int r;
        if (msg_left == 0)
        begin
            r = $urandom_range(0, 9);
            if (r < 2)
                msg_left = $urandom_range(1, 3);
            else if (r < 7)
                msg_left = $urandom_range(4, 70);
            else
                msg_left = $urandom_range(60, 200);
        end
        queue_byte(8'($urandom_range(0, 255)), msg_left == 1);
        msg_left--;
    endfunction

    initial
    begin
        int n_items;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Registers still at their reset values.
        queue_byte(8'h00, 1'b0);
        queue_byte(8'hFF, 1'b0);
        queue_byte(8'h5A, 1'b1);
        queue_byte(8'hA5, 1'b1);
        wait_drained();

        write_all('1, '1, '1, '1, '1, 32'hFFFF_FFFF);
        reg_write(REG_SPARE_A, {$urandom, $urandom});
        reg_write(REG_SPARE_B, {$urandom, $urandom});
        queue_byte(8'h00, 1'b0);
        queue_byte(8'hFF, 1'b0);
        queue_byte(8'h01, 1'b1);
        queue_byte(8'h80, 1'b1);
        queue_byte(8'h7F, 1'b0);
        queue_byte(8'hC3, 1'b0);
        wait_drained();

        // The open message must keep its counter after start_counter changes.
        write_all({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                  {$urandom, $urandom}, {$urandom, $urandom}, 32'd0);
        queue_byte(8'h3C, 1'b0);
        queue_byte(8'h96, 1'b1);
        queue_byte(8'h69, 1'b1);
        wait_drained();

        // A long message from near the top of the counter range forces a wrap.
        write_all(pick_word64(), pick_word64(), pick_word64(), pick_word64(),
                  pick_word64(), 32'hFFFF_FFFE);
        msg_left = 150;

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            if (phase == RANDOM_PHASES - 1)
                quiet = 1'b1;
            if (phase != 0)
            begin
                if ($urandom_range(0, 1) == 1) reg_write(REG_KEY_01, pick_word64());
                if ($urandom_range(0, 1) == 1) reg_write(REG_KEY_23, pick_word64());
                if ($urandom_range(0, 1) == 1) reg_write(REG_KEY_45, pick_word64());
                if ($urandom_range(0, 1) == 1) reg_write(REG_KEY_67, pick_word64());
                if ($urandom_range(0, 1) == 1) reg_write(REG_NONCE, pick_word64());
                if ($urandom_range(0, 1) == 1)
                    reg_write(REG_START_CNT, {32'd0, pick_counter()});
            end
            n_items = $urandom_range(70, 130);
            for (int i = 0; i < n_items; i++)
                queue_random_byte();
            wait_drained();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
